@@ rtl/ttup_pkg.sv @@
// ----------------------------------------------------------------------------
// ttup_pkg
// Shared word types and character class record for the text to uint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttup_pkg;

   localparam int unsigned CharWidth  = 16;
   localparam int unsigned ValueWidth = 64;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_code;
      logic                 mode;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  status;
   } rsp_type;

   typedef struct packed {
      logic       is_space;
      logic       is_zero;
      logic       is_x;
      logic       is_digit;
      logic [3:0] digit;
   } char_class_type;

endpackage

`default_nettype wire

@@ rtl/ttup_char_decode.sv @@
// ----------------------------------------------------------------------------
// ttup_char_decode
// Classifies one 16-bit character: blank, zero, x marker, digit and its value.
// ----------------------------------------------------------------------------
`default_nettype none

module ttup_char_decode (
   input  wire logic [ttup_pkg::CharWidth-1:0] char_code,
   output ttup_pkg::char_class_type             char_class
);

   always_comb begin
      char_class          = '0;
      char_class.is_space = (char_code == 16'h0020) ||
                            (char_code inside {[16'h0009:16'h000D]});
      char_class.is_zero  = (char_code == 16'h0030);
      char_class.is_x     = (char_code == 16'h0078) || (char_code == 16'h0058);
      if (char_code inside {[16'h0030:16'h0039]}) begin
         char_class.is_digit = 1'b1;
         char_class.digit    = char_code[3:0];
      end else if ((char_code inside {[16'h0061:16'h0066]}) ||
                   (char_code inside {[16'h0041:16'h0046]})) begin
         // letters a-f / A-F: low nibble 1..6 maps to 10..15
         char_class.is_digit = 1'b1;
         char_class.digit    = char_code[3:0] + 4'h9;
      end
   end

endmodule

`default_nettype wire

@@ rtl/text_to_uint_parser_unit.sv @@
// ----------------------------------------------------------------------------
// text_to_uint_parser_unit
// Parses a stream of 16-bit characters into an unsigned value with base
// detection (hex after 0x, octal after a leading 0, else decimal).
// A terminator word passes the input register, then the result register.
// Throughput: one character per cycle, a terminator waiting while the result
// register is full; the shift-add stage and one-deep result register set it.
// Reset: synchronous, clears input/result valid, phase, base and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_uint_parser_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ttup_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ttup_pkg::rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_ERROR  = 2'd3
   } phase_type;

   logic                                 s1_valid_ff, s1_valid_in;
   ttup_pkg::req_type                    s1_word_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   ttup_pkg::rsp_type                    rsp_word_ff, rsp_word_in;
   phase_type                            phase_ff, phase_in;
   ttup_pkg::radix_type                  radix_ff, radix_in;
   logic [ttup_pkg::ValueWidth-1:0]      acc_ff, acc_in;

   ttup_pkg::char_class_type             cls;
   logic                                 s1_term;
   logic                                 s1_fire;
   logic                                 req_fire;
   logic                                 bad;
   logic                                 digit_ok;
   ttup_pkg::radix_type                  digit_radix;
   logic [ttup_pkg::ValueWidth-1:0]      acc_times;
   logic [ttup_pkg::ValueWidth-1:0]      acc_step;

   ttup_char_decode u_decode (
      .char_code  (s1_word_ff.char_code),
      .char_class (cls)
   );

   assign s1_term   = (s1_word_ff.char_code == '0);
   assign s1_fire   = s1_valid_ff && (!s1_term || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // radix in force for a digit taken in this cycle
   assign digit_radix = (phase_ff == PH_SKIP) ? ttup_pkg::RADIX_DEC : radix_ff;

   always_comb begin
      case (digit_radix)
         ttup_pkg::RADIX_OCT: begin
            acc_times = acc_ff << 3;
            digit_ok  = cls.is_digit && (cls.digit < 4'd8);
         end
         ttup_pkg::RADIX_HEX: begin
            acc_times = acc_ff << 4;
            digit_ok  = cls.is_digit;
         end
         default: begin
            acc_times = (acc_ff << 3) + (acc_ff << 1);
            digit_ok  = cls.is_digit && (cls.digit < 4'd10);
         end
      endcase
      acc_step = acc_times + {{(ttup_pkg::ValueWidth-4){1'b0}}, cls.digit};
   end

   assign bad = (phase_ff == PH_ERROR) ||
                (s1_word_ff.mode && (acc_ff[ttup_pkg::ValueWidth-1:32] != '0));

   always_comb begin
      phase_in    = phase_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      rsp_word_in = rsp_word_ff;
      if (s1_term) begin
         rsp_word_in.value  = bad ? '0 : acc_ff;
         rsp_word_in.status = bad;
         phase_in           = PH_SKIP;
         radix_in           = ttup_pkg::RADIX_DEC;
         acc_in             = '0;
      end else begin
         case (phase_ff)
            PH_SKIP: begin
               if (cls.is_space) begin
                  phase_in = PH_SKIP;
               end else if (cls.is_zero) begin
                  radix_in = ttup_pkg::RADIX_OCT;
                  acc_in   = '0;
                  phase_in = PH_ZERO;
               end else begin
                  radix_in = ttup_pkg::RADIX_DEC;
                  phase_in = digit_ok ? PH_DIGITS : PH_ERROR;
                  if (digit_ok) acc_in = acc_step;
               end
            end
            PH_ZERO: begin
               if (cls.is_x) begin
                  radix_in = ttup_pkg::RADIX_HEX;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = digit_ok ? PH_DIGITS : PH_ERROR;
                  if (digit_ok) acc_in = acc_step;
               end
            end
            PH_DIGITS: begin
               phase_in = digit_ok ? PH_DIGITS : PH_ERROR;
               if (digit_ok) acc_in = acc_step;
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_term) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SKIP;
         radix_ff     <= ttup_pkg::RADIX_DEC;
         acc_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            phase_ff <= phase_in;
            radix_ff <= radix_in;
            acc_ff   <= acc_in;
         end
      end
      if (req_fire) s1_word_ff <= req_data;
      if (s1_fire && s1_term) rsp_word_ff <= rsp_word_in;
   end

   a_fail_gives_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.status) |-> (rsp_word_ff.value == '0))
      else $error("failed result word carries a nonzero value");

   a_term_restarts : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_term) |=> (phase_ff == PH_SKIP && acc_ff == '0 &&
                                radix_ff == ttup_pkg::RADIX_DEC))
      else $error("parser state not restarted after terminator");

   a_skip_acc_clear : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (acc_ff == '0))
      else $error("accumulator nonzero while skipping blanks");

   a_hex_phase : assert property (@(posedge clock) disable iff (reset)
      (radix_ff == ttup_pkg::RADIX_HEX) |->
         (phase_ff == PH_DIGITS || phase_ff == PH_ERROR))
      else $error("hex base selected outside digit or error phase");

endmodule

`default_nettype wire

@@ test/text_to_uint_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_to_uint_parser_unit_tb
// Feeds character strings (blank, decimal, octal, hex, malformed, wide codes)
// to the parser under random stalls on both sides, works out each expected
// value and status in a local model of the parser and compares every result.
// ----------------------------------------------------------------------------

module text_to_uint_parser_unit_tb;

   typedef enum logic [1:0] {PH_SKIP, PH_ZERO, PH_DIGITS, PH_FAULT} parse_phase_type;

   localparam logic [15:0] ChNul    = 16'h0000;
   localparam logic [15:0] ChTab    = 16'h0009;
   localparam logic [15:0] ChCr     = 16'h000D;
   localparam logic [15:0] ChSpace  = 16'h0020;
   localparam logic [15:0] ChZero   = 16'h0030;
   localparam logic [15:0] ChNine   = 16'h0039;
   localparam logic [15:0] ChUpperA = 16'h0041;
   localparam logic [15:0] ChUpperF = 16'h0046;
   localparam logic [15:0] ChUpperX = 16'h0058;
   localparam logic [15:0] ChLowerA = 16'h0061;
   localparam logic [15:0] ChLowerF = 16'h0066;
   localparam logic [15:0] ChLowerG = 16'h0067;
   localparam logic [15:0] ChLowerX = 16'h0078;
   localparam logic [15:0] AsciiTop = 16'h007F;
   localparam logic [63:0] Word32Max = 64'h0000_0000_FFFF_FFFF;

   localparam int ItemTarget  = 1500;
   localparam int HoldCycles  = 150;
   localparam int IdleLimit   = 3000;
   localparam int SettleCycles = 10;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ttup_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ttup_pkg::rsp_type rsp_data;

   ttup_pkg::rsp_type   pending_results[$];
   parse_phase_type     parse_phase = PH_SKIP;
   ttup_pkg::radix_type radix = ttup_pkg::RADIX_DEC;
   logic [63:0]         acc_value = '0;

   bit idle_enable  = 1'b1;
   bit hold_request = 1'b0;
   int fail_count     = 0;
   int chars_sent     = 0;
   int strings_sent   = 0;
   int results_checked = 0;
   int idle_cycles    = 0;

   text_to_uint_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (!idle_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void take_digit(input logic [15:0] c);
      logic [4:0] digit;
      logic [4:0] base;
      base = (radix == ttup_pkg::RADIX_OCT) ? 5'd8 :
             (radix == ttup_pkg::RADIX_HEX) ? 5'd16 : 5'd10;
      digit = 5'd31;
      if (c >= ChZero && c <= ChNine) digit = 5'(c - ChZero);
      else if (c >= ChLowerA && c <= ChLowerF) digit = 5'(c - ChLowerA + 16'd10);
      else if (c >= ChUpperA && c <= ChUpperF) digit = 5'(c - ChUpperA + 16'd10);
      if (digit >= base) begin
         parse_phase = PH_FAULT;
      end else begin
         acc_value = acc_value * 64'(base) + 64'(digit);
         parse_phase = PH_DIGITS;
      end
   endfunction

   function automatic void parse_word(input ttup_pkg::req_type word);
      ttup_pkg::rsp_type outcome;
      logic    bad;
      logic [15:0] c;
      c = word.char_code;
      if (c == ChNul) begin
         bad = (parse_phase == PH_FAULT) || (word.mode && acc_value > Word32Max);
         outcome.value  = bad ? '0 : acc_value;
         outcome.status = bad;
         pending_results.push_back(outcome);
         parse_phase = PH_SKIP;
         radix = ttup_pkg::RADIX_DEC;
         acc_value = '0;
         return;
      end
      case (parse_phase)
         PH_SKIP: begin
            if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
            end else if (c == ChZero) begin
               radix = ttup_pkg::RADIX_OCT;
               acc_value = '0;
               parse_phase = PH_ZERO;
            end else begin
               radix = ttup_pkg::RADIX_DEC;
               take_digit(c);
            end
         end
         PH_ZERO: begin
            if (c == ChLowerX || c == ChUpperX) begin
               radix = ttup_pkg::RADIX_HEX;
               parse_phase = PH_DIGITS;
            end else begin
               take_digit(c);
            end
         end
         PH_DIGITS: take_digit(c);
         default: ;
      endcase
   endfunction

   task automatic send_char(input logic [15:0] c, input logic m);
      ttup_pkg::req_type word;
      int gap;
      word.char_code = c;
      word.mode = m;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      parse_word(word);
      chars_sent++;
   endtask

   task automatic send_codes(input logic [15:0] text[$], input logic narrow);
      foreach (text[i]) send_char(text[i], 1'($urandom_range(0, 1)));
      send_char(ChNul, narrow);
      strings_sent++;
   endtask

   task automatic send_text(input string s, input logic narrow);
      logic [15:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back({8'h00, s[i]});
      send_codes(text, narrow);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [15:0] pick_space();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? ChSpace : ChTab + 16'(r);
   endfunction

   function automatic logic [15:0] pick_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return ChZero + 16'(v);
      return ($urandom_range(0, 1) ? ChLowerA : ChUpperA) + 16'(v - 10);
   endfunction

   function automatic logic [15:0] pick_bad_char();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(1, 65535));
         1: return 16'($urandom_range(16'h0080, 16'hFFFF));
         2: return pick_space();
         3: return ChLowerG;
         4: return ChNine;
         default: return ChLowerX;
      endcase
   endfunction

   task automatic send_random_string();
      logic [15:0] text[$];
      int kind;
      int n;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(pick_space());
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      if (kind >= 4 && kind <= 8) text.push_back(ChZero);
      if (kind >= 6 && kind <= 8) text.push_back($urandom_range(0, 1) ? ChLowerX : ChUpperX);
      repeat (n) begin
         if (kind <= 3) text.push_back(ChZero + 16'($urandom_range(0, 9)));
         else if (kind <= 5) text.push_back(ChZero + 16'($urandom_range(0, 7)));
         else if (kind <= 8) text.push_back(pick_hex_digit());
         else text.push_back(16'($urandom_range(1, 65535)));
      end
      if ($urandom_range(0, 7) == 0)
         text.insert($urandom_range(0, text.size()), pick_bad_char());
      send_codes(text, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed_cases();
      logic [15:0] text[$];
      send_text("", 1'b0);
      for (logic [15:0] c = ChTab; c <= ChCr; c++) text.push_back(c);
      text.push_back(ChSpace);
      send_codes(text, 1'b1);
      send_text("0", 1'b0);
      send_text("0x", 1'b0);
      send_text("0X", 1'b1);
      send_text("  42", 1'b0);
      send_text("0x1aF", 1'b0);
      send_text("0XDEADbeef", 1'b1);
      send_text("0777", 1'b0);
      send_text("08", 1'b0);
      send_text("0x1g", 1'b0);
      send_text("12 ", 1'b0);
      send_text("-5", 1'b0);
      send_text("1x", 1'b0);
      send_text("18446744073709551615", 1'b0);
      send_text("18446744073709551616", 1'b0);
      send_text("4294967295", 1'b1);
      send_text("4294967296", 1'b1);
      send_text("0x123456789", 1'b1);
      send_text("0xFFFFFFFFFFFFFFFFF", 1'b0);
      text.delete();
      text.push_back(ChZero + 16'd1);
      text.push_back(16'h0080);
      text.push_back(ChZero + 16'd2);
      send_codes(text, 1'b0);
      text.delete();
      text.push_back(16'hFFFF);
      send_codes(text, 1'b1);
      text.delete();
      text.push_back(AsciiTop);
      send_codes(text, 1'b0);
      drain_results();
   endtask

   task automatic test_back_to_back();
      int stop_at;
      idle_enable = 1'b0;
      stop_at = chars_sent + 200;
      while (chars_sent < stop_at) send_random_string();
      drain_results();
      idle_enable = 1'b1;
   endtask

   task automatic test_output_hold_off();
      hold_request = 1'b1;
      repeat (40) send_text($sformatf("%0d", $urandom_range(0, 999)), 1'($urandom_range(0, 1)));
      drain_results();
   endtask

   task automatic test_random_strings();
      while (chars_sent < ItemTarget) begin
         send_random_string();
         if ($urandom_range(0, 49) == 0) drain_results();
      end
      drain_results();
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            stall_left = HoldCycles;
            hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      ttup_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: value %h status %0d",
                   rsp_data.value, rsp_data.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.value !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_data.value);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no word moved for %0d cycles", IdleLimit);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      while (reset) @(posedge clock);
      test_directed_cases();
      test_back_to_back();
      test_output_hold_off();
      test_random_strings();
      drain_results();
      repeat (SettleCycles) @(posedge clock);
      $display("parsed %0d strings from %0d characters, %0d results compared",
               strings_sent, chars_sent, results_checked);
      $display("bases, wide codes, 32-bit limit and output hold-off all exercised");
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
